// ----- src/mbf_pkg.sv -----
// ----------------------------------------------------------------------------
// mbf_pkg
// Shared types and constants for the 40-bit float random generator.
// ----------------------------------------------------------------------------
package mbf_pkg;

  localparam int unsigned FLOAT_W = 40;
  localparam int unsigned EXP_W   = 8;
  localparam int unsigned MANT_W  = 32;

  localparam logic [EXP_W-1:0] EXP_BIAS = 8'h80;
  localparam logic [EXP_W-1:0] EXP_MAX  = 8'hFF;

  localparam logic [FLOAT_W-1:0] MULT_RESET = 40'd653424376320;
  localparam logic [FLOAT_W-1:0] ADD_RESET  = 40'd447428363776;

  localparam int unsigned MUL_STEPS = 40;

  // configuration register indexes
  localparam logic CFG_MULT = 1'b0;
  localparam logic CFG_ADD  = 1'b1;

  localparam logic MODE_NEXT = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM1,
    ST_REV,
    ST_NORM2,
    ST_FIN,
    ST_LOAD
  } mbf_state_e;

  // unpacked working mantissa: implicit one, 31 fraction bits, rounding byte
  function automatic logic [FLOAT_W-1:0] unpack_mant(input logic [FLOAT_W-1:0] f);
    unpack_mant = {1'b1, f[30:0], 8'h00};
  endfunction

  function automatic logic [MANT_W-1:0] byte_rev(input logic [MANT_W-1:0] m);
    byte_rev = {m[7:0], m[15:8], m[23:16], m[31:24]};
  endfunction

endpackage

// ----- src/mbf_in_if.sv -----
// ----------------------------------------------------------------------------
// mbf_in_if
// Request channel: mode and packed seed to load.
// ----------------------------------------------------------------------------
interface mbf_in_if
  import mbf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [FLOAT_W-1:0] load_value;

  modport source (output valid, output mode, output load_value, input ready);
  modport sink   (input valid, input mode, input load_value, output ready);
endinterface

// ----- src/mbf_out_if.sv -----
// ----------------------------------------------------------------------------
// mbf_out_if
// Result channel: new packed seed and the unrounded value.
// ----------------------------------------------------------------------------
interface mbf_out_if
  import mbf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FLOAT_W-1:0] seed_out;
  logic [EXP_W-1:0]   value_exponent;
  logic [MANT_W-1:0]  value_mantissa;
  logic               below_half;

  modport source (output valid, output seed_out, output value_exponent,
                  output value_mantissa, output below_half, input ready);
  modport sink   (input valid, input seed_out, input value_exponent,
                  input value_mantissa, input below_half, output ready);
endinterface

// ----- src/mbf_float_rnd_generator.sv -----
// ----------------------------------------------------------------------------
// mbf_float_rnd_generator
// Multiplicative random generator on five-byte binary floats.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                         handshake
//  in_i      in   mode, load_value                                valid/ready
//  out_o     out  seed_out, value_exponent, value_mantissa,       valid/ready
//                 below_half
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i                write only
//
// Load stores load_value as the seed and returns it. Next runs the 40-step
// shift-and-add multiply on one 40-bit adder, plus two normalizations that
// shift one byte or one bit per cycle; the multiply is skipped (zero seed
// or multiplier exponent, or exponent sum below bias).
// One transaction is in work at a time. Reset clears the seed to zero and
// the constants to their defaults. A stalled result holds in the output
// register; the finishing step waits for the register to free up, and no new
// request is accepted until it has.
// ----------------------------------------------------------------------------
module mbf_float_rnd_generator
  import mbf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [FLOAT_W-1:0] cfg_wdata_i,
  mbf_in_if.sink             in_i,
  mbf_out_if.source          out_o
);

  mbf_state_e state_q, state_d;

  logic [FLOAT_W-1:0] mult_q, add_q, seed_q, seed_d;
  logic [EXP_W-1:0]   exp_q, exp_d;
  logic [FLOAT_W-1:0] mant_q, mant_d;
  logic [FLOAT_W-1:0] mul_q, mul_d;
  logic [5:0]         cnt_q, cnt_d;

  logic               out_valid_q, out_valid_d;
  logic [FLOAT_W-1:0] out_seed_q, out_seed_d;
  logic [EXP_W-1:0]   out_exp_q, out_exp_d;
  logic [MANT_W-1:0]  out_mant_q, out_mant_d;
  logic               out_half_q, out_half_d;

  logic               in_fire, out_free;
  logic [EXP_W:0]     exp_sum;
  logic [FLOAT_W:0]   acc_sum;
  logic               norm_done;
  logic [EXP_W-1:0]   norm_exp;
  logic [FLOAT_W-1:0] norm_mant;
  logic [EXP_W-1:0]   rev_exp;
  logic [FLOAT_W-1:0] rev_mant;
  logic [MANT_W:0]    rnd_sum;
  logic [EXP_W-1:0]   rnd_exp;
  logic [MANT_W-1:0]  rnd_mant;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid          = out_valid_q;
  assign out_o.seed_out       = out_seed_q;
  assign out_o.value_exponent = out_exp_q;
  assign out_o.value_mantissa = out_mant_q;
  assign out_o.below_half     = out_half_q;

  assign exp_sum = {1'b0, seed_q[39:32]} + {1'b0, mult_q[39:32]};

  // shared adder: one multiplier bit per cycle, result shifted right
  assign acc_sum = {1'b0, mant_q} + (mul_q[0] ? {1'b0, unpack_mant(mult_q)} : '0);

  // one normalization step per cycle: byte shift first, then bit shifts
  always_comb begin
    norm_done = (exp_q == '0) || mant_q[FLOAT_W-1];
    norm_exp  = exp_q;
    norm_mant = mant_q;
    if (mant_q[39:32] == '0) begin
      if (exp_q <= 8'd8) begin
        norm_exp = '0;
      end else begin
        norm_exp  = exp_q - 8'd8;
        norm_mant = {mant_q[31:0], 8'h00};
      end
    end else begin
      if (exp_q <= 8'd1) begin
        norm_exp = '0;
      end else begin
        norm_exp  = exp_q - 8'd1;
        norm_mant = {mant_q[38:0], 1'b0};
      end
    end
  end

  // zero product takes the addend; then swap mantissa bytes
  always_comb begin
    rev_exp  = exp_q;
    rev_mant = mant_q;
    if (exp_q == '0 && add_q[39:32] != '0) begin
      rev_exp  = add_q[39:32];
      rev_mant = unpack_mant(add_q);
    end
  end

  assign rnd_sum = {1'b0, mant_q[39:8]} + {{MANT_W{1'b0}}, mant_q[7]};
  always_comb begin
    rnd_exp  = exp_q;
    rnd_mant = rnd_sum[MANT_W-1:0];
    if (rnd_sum[MANT_W]) begin
      rnd_mant = 32'h8000_0000;
      rnd_exp  = exp_q + 8'd1;
    end
  end

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    mant_d      = mant_q;
    mul_d       = mul_q;
    cnt_d       = cnt_q;
    seed_d      = seed_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_seed_d  = out_seed_q;
    out_exp_d   = out_exp_q;
    out_mant_d  = out_mant_q;
    out_half_d  = out_half_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d = '0;
          if (in_i.mode == MODE_LOAD) begin
            mant_d  = in_i.load_value;
            state_d = ST_LOAD;
          end else begin
            exp_d  = seed_q[39:32];
            mant_d = unpack_mant(seed_q);
            mul_d  = unpack_mant(seed_q);
            if (seed_q[39:32] == '0) begin
              state_d = ST_NORM1;
            end else if (mult_q[39:32] == '0 || exp_sum < 9'(EXP_BIAS)) begin
              exp_d   = '0;
              mant_d  = '0;
              state_d = ST_NORM1;
            end else begin
              exp_d   = (exp_sum - 9'(EXP_BIAS) > 9'(EXP_MAX)) ? EXP_MAX
                        : 8'(exp_sum - 9'(EXP_BIAS));
              mant_d  = '0;
              state_d = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        mant_d = acc_sum[FLOAT_W:1];
        mul_d  = {1'b0, mul_q[FLOAT_W-1:1]};
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'(MUL_STEPS - 1)) begin
          state_d = ST_NORM1;
        end
      end
      ST_NORM1: begin
        if (norm_done) begin
          state_d = ST_REV;
        end else begin
          exp_d  = norm_exp;
          mant_d = norm_mant;
        end
      end
      ST_REV: begin
        mant_d  = {byte_rev(rev_mant[39:8]), rev_exp};
        exp_d   = EXP_BIAS;
        state_d = ST_NORM2;
      end
      ST_NORM2: begin
        if (norm_done) begin
          state_d = ST_FIN;
        end else begin
          exp_d  = norm_exp;
          mant_d = norm_mant;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_exp_d   = exp_q;
          out_half_d  = (exp_q < EXP_BIAS);
          if (exp_q == '0) begin
            out_mant_d = '0;
            seed_d     = '0;
          end else begin
            out_mant_d = mant_q[39:8];
            seed_d     = {rnd_exp, 1'b0, rnd_mant[30:0]};
          end
          out_seed_d = seed_d;
          state_d    = ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          seed_d      = mant_q;
          out_valid_d = 1'b1;
          out_seed_d  = mant_q;
          out_exp_d   = '0;
          out_mant_d  = '0;
          out_half_d  = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= '0;
      mult_q      <= MULT_RESET;
      add_q       <= ADD_RESET;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MULT: mult_q <= cfg_wdata_i;
          CFG_ADD:  add_q  <= cfg_wdata_i;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q      <= exp_d;
    mant_q     <= mant_d;
    mul_q      <= mul_d;
    out_seed_q <= out_seed_d;
    out_exp_q  <= out_exp_d;
    out_mant_q <= out_mant_d;
    out_half_q <= out_half_d;
  end

  // multiply sequencer never runs past its last step
  a_mul_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> cnt_q < 6'(MUL_STEPS))
    else $error("multiply step count overrun");

  // an accepted request always starts work
  a_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("accepted request dropped");

  // a nonzero exponent result carries a normalized mantissa
  a_norm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_exp_q != '0 |-> out_mant_q[MANT_W-1])
    else $error("result mantissa not normalized");

  // second normalization works from the fixed bias downward
  a_norm2_exp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_NORM2 |-> exp_q <= EXP_BIAS)
    else $error("exponent above bias after byte swap");

  // result register is only loaded from the finishing states
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN || $past(state_q) == ST_LOAD)
    else $error("unexpected result write");

endmodule

// ----- tb/mbf_rnd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbf_rnd_checker
// Watches the config port and both channels of the float random generator,
// keeps its own copy of seed and constants, predicts each draw and compares.
// ----------------------------------------------------------------------------
module mbf_rnd_checker
  import mbf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [FLOAT_W-1:0] cfg_wdata_i,
  mbf_in_if                  in_mon,
  mbf_out_if                 out_mon,
  output int unsigned        fail_cnt_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic [FLOAT_W-1:0] seed;
    logic [EXP_W-1:0]   vexp;
    logic [MANT_W-1:0]  vmant;
    logic               half;
  } draw_t;

  logic [FLOAT_W-1:0] mult_k;
  logic [FLOAT_W-1:0] add_k;
  logic [FLOAT_W-1:0] seed_q;
  draw_t              pending_draws[$];
  draw_t              got;
  draw_t              want;
  int unsigned        fails;
  int unsigned        draws_seen;

  // byte-then-bit normalization; exponent hitting zero flushes the value
  function automatic void float_normalize(inout int unsigned e, inout logic [39:0] m);
    if (e == 0) return;
    while (m[39:32] == 8'h00) begin
      if (e <= 8) begin
        e = 0;
        return;
      end
      e = e - 8;
      m = m << 8;
    end
    while (!m[39]) begin
      if (e <= 1) begin
        e = 0;
        return;
      end
      e = e - 1;
      m = m << 1;
    end
  endfunction

  // shift-and-add over 40 multiplier bits, carry folded back into bit 39
  function automatic void float_mul(inout int unsigned e, inout logic [39:0] m,
                                    input logic [FLOAT_W-1:0] k);
    int unsigned kexp;
    int unsigned esum;
    logic [39:0] k_mant;
    logic [40:0] acc;
    int          i;
    kexp = k[39:32];
    if (e == 0) return;
    if (kexp == 0 || e + kexp < 128) begin
      e = 0;
      m = '0;
      return;
    end
    esum = e + kexp - 128;
    if (esum > 255) esum = 255;
    k_mant = {1'b1, k[30:0], 8'h00};
    acc = '0;
    for (i = 0; i < 40; i++) begin
      if (m[i]) acc = {1'b0, acc[39:0]} + {1'b0, k_mant};
      acc = acc >> 1;
    end
    e = esum;
    m = acc[39:0];
    float_normalize(e, m);
  endfunction

  function automatic draw_t advance_seed(input logic mode, input logic [FLOAT_W-1:0] lv);
    draw_t        d;
    int unsigned  e;
    logic [39:0]  m;
    logic [31:0]  r32;
    logic [31:0]  rm;
    logic [7:0]   re;
    if (mode == MODE_LOAD) begin
      seed_q  = lv;
      d.seed  = lv;
      d.vexp  = '0;
      d.vmant = '0;
      d.half  = 1'b0;
      return d;
    end
    e = seed_q[39:32];
    m = {1'b1, seed_q[30:0], 8'h00};
    float_mul(e, m, mult_k);
    if (e == 0 && add_k[39:32] != 8'h00) begin
      e = add_k[39:32];
      m = {1'b1, add_k[30:0], 8'h00};
    end
    // swap mantissa bytes, old exponent drops into the rounding byte
    r32 = m[39:8];
    m = {r32[7:0], r32[15:8], r32[23:16], r32[31:24], e[7:0]};
    e = 128;
    float_normalize(e, m);
    d.vexp  = e[7:0];
    d.vmant = (e != 0) ? m[39:8] : '0;
    d.half  = (e < 128);
    if (e == 0) begin
      seed_q = '0;
    end else begin
      re = e[7:0];
      rm = m[39:8];
      if (m[7]) begin
        rm = rm + 32'd1;
        if (rm == 32'd0) begin
          rm = 32'h8000_0000;
          re = re + 8'd1;
        end
      end
      seed_q = {re, 1'b0, rm[30:0]};
    end
    d.seed = seed_q;
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_k = MULT_RESET;
      add_k  = ADD_RESET;
      seed_q = '0;
      pending_draws.delete();
      fails      = 0;
      draws_seen = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MULT) mult_k = cfg_wdata_i;
        else add_k = cfg_wdata_i;
      end
      // check outputs before queuing this cycle's request
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.seed_out, out_mon.value_exponent, out_mon.value_mantissa,
               out_mon.below_half};
        if (pending_draws.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("draw %0d: unexpected transaction seed %h", draws_seen, got.seed);
        end else begin
          want = pending_draws.pop_front();
          if (got.seed !== want.seed || got.vexp !== want.vexp ||
              got.vmant !== want.vmant || got.half !== want.half) begin
            fails++;
            if (fails <= 10)
              $display("draw %0d mismatch: seed %h/%h exp %h/%h mant %h/%h half %b/%b",
                       draws_seen, want.seed, got.seed, want.vexp, got.vexp,
                       want.vmant, got.vmant, want.half, got.half);
          end
        end
        draws_seen++;
      end
      if (in_mon.valid && in_mon.ready)
        pending_draws.push_back(advance_seed(in_mon.mode, in_mon.load_value));
      fail_cnt_o <= fails;
      pending_o  <= pending_draws.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the float random generator: directed corner cases, then random
// phases with random constants, random idling on both channels, one long
// output stall and a mid-run drain. Verdict from the checker's counts.
// ----------------------------------------------------------------------------
module tb;
  import mbf_pkg::*;

  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned RAND_PHASES    = 6;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned TAIL_CYCLES    = 100;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [FLOAT_W-1:0] cfg_wdata_i;
  logic               calm;
  logic               rx_hold_req;
  int unsigned        fail_cnt;
  int unsigned        pending_cnt;
  int unsigned        quiet_cycles;

  mbf_in_if  in_if ();
  mbf_out_if out_if ();

  mbf_float_rnd_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  mbf_rnd_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // no transaction on either channel for too long ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  function automatic logic [FLOAT_W-1:0] rand_float();
    logic [FLOAT_W-1:0] f;
    f[31:0]  = $urandom;
    f[39:32] = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: f = '0;
      1: f = '1;
      2, 3, 4, 5: f[39:32] = $urandom_range(120, 136);
      default: ;
    endcase
    return f;
  endfunction

  // returns at the rising edge where the transaction was taken
  task automatic send_item(input logic mode, input logic [FLOAT_W-1:0] lv);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= mode;
    in_if.load_value <= lv;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [FLOAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_NEXT;
    in_if.load_value = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_MULT;
    cfg_wdata_i      = '0;
    calm             = 1'b0;
    rx_hold_req      = 1'b0;
    rst_ni           = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset constants; first draw starts from the zero seed
    send_item(MODE_NEXT, '0);
    send_item(MODE_NEXT, '0);
    send_item(MODE_LOAD, 40'h00_0000_0000);
    send_item(MODE_NEXT, '1);
    send_item(MODE_LOAD, 40'hFF_FFFF_FFFF);
    send_item(MODE_NEXT, '0);
    send_item(MODE_LOAD, 40'h80_0000_0000);
    send_item(MODE_NEXT, '0);
    send_item(MODE_LOAD, 40'h01_7FFF_FFFF);
    send_item(MODE_NEXT, '0);
    send_item(MODE_LOAD, 40'h00_FFFF_FFFF);
    send_item(MODE_NEXT, '0);

    // zero multiplier and zero addend: product zero, value underflows
    drain();
    write_cfg(CFG_MULT, '0);
    write_cfg(CFG_ADD, '0);
    send_item(MODE_LOAD, 40'h80_1234_5678);
    send_item(MODE_NEXT, '0);
    send_item(MODE_LOAD, 40'h00_8000_000F);
    send_item(MODE_NEXT, '0);

    // all-ones addend mantissa forces a carry out of rounding
    drain();
    write_cfg(CFG_ADD, 40'hFF_7FFF_FFFF);
    send_item(MODE_NEXT, '0);

    // tiny multiplier exponent: sum below bias
    drain();
    write_cfg(CFG_MULT, 40'h01_0000_0000);
    write_cfg(CFG_ADD, ADD_RESET);
    send_item(MODE_LOAD, 40'h10_5555_5555);
    send_item(MODE_NEXT, '0);

    // max multiplier: exponent saturates
    drain();
    write_cfg(CFG_MULT, 40'hFF_FFFF_FFFF);
    send_item(MODE_LOAD, 40'hFF_FFFF_FFFF);
    send_item(MODE_NEXT, '0);
    send_item(MODE_LOAD, 40'hC0_AAAA_AAAA);
    send_item(MODE_NEXT, '0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      write_cfg(CFG_MULT, rand_float());
      write_cfg(CFG_ADD, rand_float());
      calm <= (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 40) rx_hold_req = 1'b1;
        if (ph == 4 && n == 75) drain();
        send_item(($urandom_range(0, 99) < 15) ? MODE_LOAD : MODE_NEXT, rand_float());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
